FILE: rtl/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared constants for the cut point extraction block: default widths and
// the column mode codes.
// ----------------------------------------------------------------------------
package cpe_pkg;

  localparam int CPE_VALUE_WIDTH = 32;
  localparam int CPE_CLASS_WIDTH = 8;
  localparam int CPE_MODE_WIDTH  = 2;

  typedef logic [CPE_MODE_WIDTH-1:0] cpe_mode_t;

  // Column modes; the unused fourth code behaves as categorical
  localparam cpe_mode_t MODE_NUMERICAL   = 2'd0;
  localparam cpe_mode_t MODE_ORDERED     = 2'd1;
  localparam cpe_mode_t MODE_CATEGORICAL = 2'd2;

endpackage

FILE: rtl/cpe_core.sv
// ----------------------------------------------------------------------------
// cpe_core
// Column scan state and combinational cut point decision. State advances on
// every accepted word; the result is combinational from the input word and
// the registered column state.
// ----------------------------------------------------------------------------
module cpe_core
  import cpe_pkg::*;
#(
  parameter int VALUE_WIDTH = CPE_VALUE_WIDTH,
  parameter int CLASS_WIDTH = CPE_CLASS_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic        [CLASS_WIDTH-1:0] class_label,
  input  cpe_mode_t                     mode,
  input  logic                          column_last,
  output logic                          cut_valid,
  output logic signed [VALUE_WIDTH:0]   cut_value,
  output logic                          column_end
);

  logic [VALUE_WIDTH-1:0] anchor_value_r, anchor_value_nxt;
  logic                   anchor_valid_r, anchor_valid_nxt;
  logic [VALUE_WIDTH-1:0] last_value_r;
  logic [CLASS_WIDTH-1:0] last_class_r;
  logic                   tie_pending_r, tie_pending_nxt;
  logic                   column_started_r;
  cpe_mode_t              column_mode_r, column_mode_nxt;

  logic [VALUE_WIDTH-1:0] anchor_eff;
  logic                   same_as_last;
  logic signed [VALUE_WIDTH:0] mid_sum;

  assign column_mode_nxt = column_started_r ? column_mode_r : mode;
  assign same_as_last    = (last_value_r == value);

  // reference moves up to the previous item when the value changed or no reference is held
  assign anchor_eff = (!anchor_valid_r || !same_as_last) ? last_value_r : anchor_value_r;
  assign mid_sum    = $signed({anchor_eff[VALUE_WIDTH-1], anchor_eff})
                    + $signed({value[VALUE_WIDTH-1], value});

  always_comb begin
    cut_valid        = 1'b0;
    cut_value        = '0;
    anchor_value_nxt = anchor_value_r;
    anchor_valid_nxt = anchor_valid_r;
    tie_pending_nxt  = tie_pending_r;
    case (column_mode_nxt)
      MODE_NUMERICAL: begin
        if (column_started_r) begin
          anchor_value_nxt = anchor_eff;
          anchor_valid_nxt = 1'b1;
          if (last_class_r != class_label) begin
            if (anchor_eff != value) begin
              cut_valid        = 1'b1;
              cut_value        = mid_sum;
              tie_pending_nxt  = same_as_last;
              anchor_value_nxt = value;
            end else begin
              tie_pending_nxt = 1'b1;
            end
          end else if (tie_pending_r && (anchor_eff != value)) begin
            cut_valid        = 1'b1;
            cut_value        = mid_sum;
            tie_pending_nxt  = 1'b0;
            anchor_value_nxt = value;
          end
        end
      end
      MODE_ORDERED: begin
        if (column_started_r && !same_as_last) begin
          cut_valid = 1'b1;
          cut_value = {last_value_r, 1'b0};
        end
      end
      default: begin
        if (!column_started_r || !same_as_last) begin
          cut_valid = 1'b1;
          cut_value = {value, 1'b0};
        end
      end
    endcase
    if (column_last) begin
      anchor_valid_nxt = 1'b0;
      tie_pending_nxt  = 1'b0;
    end
  end

  assign column_end = column_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_value_r   <= '0;
      anchor_valid_r   <= 1'b0;
      last_value_r     <= '0;
      last_class_r     <= '0;
      tie_pending_r    <= 1'b0;
      column_started_r <= 1'b0;
      column_mode_r    <= MODE_NUMERICAL;
    end else if (accept) begin
      anchor_value_r   <= anchor_value_nxt;
      anchor_valid_r   <= anchor_valid_nxt;
      last_value_r     <= value;
      last_class_r     <= class_label;
      tie_pending_r    <= tie_pending_nxt;
      column_started_r <= !column_last;
      column_mode_r    <= column_mode_nxt;
    end
  end

endmodule

FILE: rtl/cut_point_extraction_top.sv
// ----------------------------------------------------------------------------
// cut_point_extraction_top
// Cut point extraction for one sorted attribute column per frame.
// ----------------------------------------------------------------------------
// Takes one observation word per cycle while the skid stage is empty and
// returns exactly one registered result word for each, in order. The rate
// is set by the combinational compare and add against the registered column
// state; a result register plus a skid stage keep input acceptance going
// for one more word while the result side stalls. The column mode is
// latched from the first word of a column (after reset or after a word with
// in_tlast set); cut values are in half-LSB units (value sum for a midpoint,
// doubled value otherwise) and read zero when no cut is flagged.
module cut_point_extraction_top
  import cpe_pkg::*;
#(
  parameter int VALUE_WIDTH = CPE_VALUE_WIDTH,
  parameter int CLASS_WIDTH = CPE_CLASS_WIDTH,
  localparam int IN_DATA_WIDTH  = ((VALUE_WIDTH + CLASS_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_WIDTH = ((VALUE_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DATA_WIDTH-1:0]  in_tdata,   // value, class_label
  input  cpe_mode_t                 in_tuser,   // mode
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_WIDTH-1:0] out_tdata,  // cut_value
  output logic                      out_tuser,  // cut_valid
  output logic                      out_tlast
);

  logic                        in_accept;
  logic                        res_cut_valid;
  logic signed [VALUE_WIDTH:0] res_cut_value;
  logic                        res_column_end;

  logic                        out_valid_r;
  logic                        out_cut_valid_r;
  logic [VALUE_WIDTH:0]        out_cut_value_r;
  logic                        out_column_end_r;
  logic                        skid_valid_r;
  logic                        skid_cut_valid_r;
  logic [VALUE_WIDTH:0]        skid_cut_value_r;
  logic                        skid_column_end_r;
  logic                        main_free;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign main_free = out_tready || !out_valid_r;

  cpe_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CLASS_WIDTH (CLASS_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .value       (in_tdata[VALUE_WIDTH-1:0]),
    .class_label (in_tdata[VALUE_WIDTH+CLASS_WIDTH-1:VALUE_WIDTH]),
    .mode        (in_tuser),
    .column_last (in_tlast),
    .cut_valid   (res_cut_valid),
    .cut_value   (res_cut_value),
    .column_end  (res_column_end)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      // skid drains first; input is held off while it is full
      out_valid_r  <= skid_valid_r || in_accept;
      skid_valid_r <= 1'b0;
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        out_cut_valid_r  <= skid_cut_valid_r;
        out_cut_value_r  <= skid_cut_value_r;
        out_column_end_r <= skid_column_end_r;
      end else if (in_accept) begin
        out_cut_valid_r  <= res_cut_valid;
        out_cut_value_r  <= res_cut_value;
        out_column_end_r <= res_column_end;
      end
    end else if (in_accept) begin
      skid_cut_valid_r  <= res_cut_valid;
      skid_cut_value_r  <= res_cut_value;
      skid_column_end_r <= res_column_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_WIDTH'(out_cut_value_r);
  assign out_tuser  = out_cut_valid_r;
  assign out_tlast  = out_column_end_r;

endmodule
